/* hw/rtl/qau_pkg.sv */
// Shared types, command codes and fixed-point constants of the quaternion arithmetic unit.
package qau_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned PROD_W = 2 * DATA_W;
    localparam int unsigned SUM_W  = PROD_W + 4;
    localparam int unsigned FRAC_W = 14;
    localparam int unsigned N_LANE = 4;
    localparam int unsigned N_TERM = 4;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_SUB    = 3'd1;
    localparam logic [2:0] CMD_MUL    = 3'd2;
    localparam logic [2:0] CMD_SCALE  = 3'd3;
    localparam logic [2:0] CMD_CONJ   = 3'd4;
    localparam logic [2:0] CMD_MATRIX = 3'd5;

    localparam logic [1:0] COL_LAST = 2'd3;

    // 1.0 in Q2.14
    localparam logic [DATA_W-1:0] Q_ONE = 16'h4000;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] a_w;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
        logic signed [DATA_W-1:0] b_w;
        logic signed [DATA_W-1:0] factor;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_0;
        logic signed [DATA_W-1:0] res_1;
        logic signed [DATA_W-1:0] res_2;
        logic signed [DATA_W-1:0] res_3;
        logic                     last;
    } t_res;

    // One output lane: sum of signed products, optionally doubled, plus optional 1.0
    typedef struct packed {
        logic [N_TERM-1:0][DATA_W-1:0] m;
        logic [N_TERM-1:0][DATA_W-1:0] n;
        logic [N_TERM-1:0]             neg;
        logic                          dbl;
        logic                          one;
    } t_lane_op;

    typedef struct packed {
        logic emit;
        logic last;
        logic done;
    } t_dec_info;

endpackage

/* hw/rtl/qau_stream_if.sv */
// Valid/ready stream interface used for the request and result channels.
interface qau_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/qau_lane.sv */
// One result lane: four signed products, signed sum, round to nearest and saturate.
module qau_lane (
    input  qau_pkg::t_lane_op                  i_op,
    output logic signed [qau_pkg::DATA_W-1:0]  o_val
);
    import qau_pkg::*;

    localparam int unsigned RND_W = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] ONE_Q  = SUM_W'(1) <<< (2 * FRAC_W);
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(32768);

    logic signed [PROD_W-1:0] prod [N_TERM];
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  scaled;
    logic signed [SUM_W-1:0]  biased;
    logic signed [RND_W-1:0]  rounded;

    always_comb begin
        acc = '0;
        for (int k = 0; k < N_TERM; k++) begin
            prod[k] = $signed(i_op.m[k]) * $signed(i_op.n[k]);
            if (i_op.neg[k]) begin
                acc = acc - SUM_W'(prod[k]);
            end else begin
                acc = acc + SUM_W'(prod[k]);
            end
        end
        scaled  = i_op.dbl ? (acc <<< 1) : acc;
        biased  = scaled + (i_op.one ? ONE_Q : '0) + HALF;
        rounded = biased[SUM_W-1:FRAC_W];
        if (rounded > SAT_HI) begin
            o_val = SAT_HI[DATA_W-1:0];
        end else if (rounded < SAT_LO) begin
            o_val = SAT_LO[DATA_W-1:0];
        end else begin
            o_val = rounded[DATA_W-1:0];
        end
    end
endmodule

/* hw/rtl/qau_decode.sv */
// Maps a request and matrix column onto the operand selection of the four lanes.
module qau_decode (
    input  qau_pkg::t_req                          i_req,
    input  logic [1:0]                             i_col,
    output qau_pkg::t_lane_op [qau_pkg::N_LANE-1:0] o_ops,
    output qau_pkg::t_dec_info                     o_info
);
    import qau_pkg::*;

    function automatic t_lane_op mk(
        input logic [DATA_W-1:0] m0, input logic [DATA_W-1:0] n0, input logic ng0,
        input logic [DATA_W-1:0] m1, input logic [DATA_W-1:0] n1, input logic ng1,
        input logic [DATA_W-1:0] m2, input logic [DATA_W-1:0] n2, input logic ng2,
        input logic [DATA_W-1:0] m3, input logic [DATA_W-1:0] n3, input logic ng3,
        input logic dbl, input logic one);
        t_lane_op op;
        op.m   = {m3, m2, m1, m0};
        op.n   = {n3, n2, n1, n0};
        op.neg = {ng3, ng2, ng1, ng0};
        op.dbl = dbl;
        op.one = one;
        return op;
    endfunction

    logic [DATA_W-1:0] ax, ay, az, aw, bx, by, bz, bw, f;
    logic [DATA_W-1:0] z0;

    assign ax = i_req.a_x;
    assign ay = i_req.a_y;
    assign az = i_req.a_z;
    assign aw = i_req.a_w;
    assign bx = i_req.b_x;
    assign by = i_req.b_y;
    assign bz = i_req.b_z;
    assign bw = i_req.b_w;
    assign f  = i_req.factor;
    assign z0 = '0;

    always_comb begin
        o_ops       = '0;
        o_info.emit = 1'b1;
        o_info.last = 1'b1;
        o_info.done = 1'b1;
        case (i_req.command)
            CMD_ADD, CMD_SUB: begin
                // pass through 1.0 multiplies so the lanes saturate the sums
                o_ops[0] = mk(ax, Q_ONE, 1'b0, bx, Q_ONE, i_req.command == CMD_SUB,
                              z0, z0, 1'b0, z0, z0, 1'b0, 1'b0, 1'b0);
                o_ops[1] = mk(ay, Q_ONE, 1'b0, by, Q_ONE, i_req.command == CMD_SUB,
                              z0, z0, 1'b0, z0, z0, 1'b0, 1'b0, 1'b0);
                o_ops[2] = mk(az, Q_ONE, 1'b0, bz, Q_ONE, i_req.command == CMD_SUB,
                              z0, z0, 1'b0, z0, z0, 1'b0, 1'b0, 1'b0);
                o_ops[3] = mk(aw, Q_ONE, 1'b0, bw, Q_ONE, i_req.command == CMD_SUB,
                              z0, z0, 1'b0, z0, z0, 1'b0, 1'b0, 1'b0);
            end
            CMD_MUL: begin
                o_ops[0] = mk(aw, bx, 1'b0, ax, bw, 1'b0, ay, bz, 1'b0, az, by, 1'b1,
                              1'b0, 1'b0);
                o_ops[1] = mk(aw, by, 1'b0, ay, bw, 1'b0, az, bx, 1'b0, ax, bz, 1'b1,
                              1'b0, 1'b0);
                o_ops[2] = mk(aw, bz, 1'b0, az, bw, 1'b0, ax, by, 1'b0, ay, bx, 1'b1,
                              1'b0, 1'b0);
                o_ops[3] = mk(aw, bw, 1'b0, ax, bx, 1'b1, ay, by, 1'b1, az, bz, 1'b1,
                              1'b0, 1'b0);
            end
            CMD_SCALE: begin
                o_ops[0] = mk(ax, f, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0,
                              1'b0, 1'b0);
                o_ops[1] = mk(ay, f, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0,
                              1'b0, 1'b0);
                o_ops[2] = mk(az, f, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0,
                              1'b0, 1'b0);
                o_ops[3] = mk(aw, f, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0,
                              1'b0, 1'b0);
            end
            CMD_CONJ: begin
                o_ops[0] = mk(ax, Q_ONE, 1'b1, z0, z0, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0,
                              1'b0, 1'b0);
                o_ops[1] = mk(ay, Q_ONE, 1'b1, z0, z0, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0,
                              1'b0, 1'b0);
                o_ops[2] = mk(az, Q_ONE, 1'b1, z0, z0, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0,
                              1'b0, 1'b0);
                o_ops[3] = mk(aw, Q_ONE, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0, z0, z0, 1'b0,
                              1'b0, 1'b0);
            end
            CMD_MATRIX: begin
                o_info.last = (i_col == COL_LAST);
                o_info.done = (i_col == COL_LAST);
                case (i_col)
                    2'd0: begin
                        o_ops[0] = mk(ay, ay, 1'b1, az, az, 1'b1, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b1);
                        o_ops[1] = mk(ax, ay, 1'b0, az, aw, 1'b1, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b0);
                        o_ops[2] = mk(ax, az, 1'b0, ay, aw, 1'b0, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b0);
                    end
                    2'd1: begin
                        o_ops[0] = mk(ax, ay, 1'b0, az, aw, 1'b0, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b0);
                        o_ops[1] = mk(ax, ax, 1'b1, az, az, 1'b1, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b1);
                        o_ops[2] = mk(ay, az, 1'b0, ax, aw, 1'b1, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b0);
                    end
                    2'd2: begin
                        o_ops[0] = mk(ax, az, 1'b0, ay, aw, 1'b1, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b0);
                        o_ops[1] = mk(ay, az, 1'b0, ax, aw, 1'b0, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b0);
                        o_ops[2] = mk(ax, ax, 1'b1, ay, ay, 1'b1, z0, z0, 1'b0,
                                      z0, z0, 1'b0, 1'b1, 1'b1);
                    end
                    default: begin
                        // homogeneous column: only the bottom entry is 1.0
                        o_ops[3].one = 1'b1;
                    end
                endcase
            end
            default: begin
                // unused codes: drop the request without a result
                o_info.emit = 1'b0;
            end
        endcase
    end
endmodule

/* hw/rtl/quaternion_arithmetic_unit.sv */
// Quaternion arithmetic unit: add, subtract, Hamilton product, scale, conjugate and
// rotation matrix on signed Q2.14 components, with round-to-nearest and saturation.
// A request is held in the request register while four product/sum lanes compute
// its result combinationally into the result register. One request is taken per
// cycle unless the result side stalls or a matrix command is in progress. The
// matrix command holds the request register for four results, one per matrix
// column, with last set on the fourth; codes 6 and 7 are taken and give no result.
// While a finished result waits for the consumer, one more request can still be
// taken into the request register; then requests stall until the result is taken.
module quaternion_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qau_stream_if.sink   i_req,
    qau_stream_if.source o_res
);
    import qau_pkg::*;

    logic                     r_in_valid;
    t_req                     r_in;
    logic [1:0]               r_col;
    logic                     r_out_valid;
    t_res                     r_out;

    t_lane_op [N_LANE-1:0]    lane_ops;
    t_dec_info                info;
    logic signed [DATA_W-1:0] lane_val [N_LANE];
    logic                     advance;
    logic                     take;

    qau_decode u_decode (
        .i_req  (r_in),
        .i_col  (r_col),
        .o_ops  (lane_ops),
        .o_info (info)
    );

    for (genvar g = 0; g < N_LANE; g++) begin : g_lane
        qau_lane u_lane (
            .i_op  (lane_ops[g]),
            .o_val (lane_val[g])
        );
    end

    // result register free or being emptied this cycle
    assign advance     = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || (advance && info.done);
    assign take        = i_req.valid && i_req.ready;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (r_in_valid && advance) begin
                r_col <= info.done ? 2'd0 : r_col + 2'd1;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && info.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_req.data;
        end
        if (advance) begin
            r_out.res_0 <= lane_val[0];
            r_out.res_1 <= lane_val[1];
            r_out.res_2 <= lane_val[2];
            r_out.res_3 <= lane_val[3];
            r_out.last  <= info.last;
        end
    end
endmodule

/* tb/tb.sv */
// Self-checking testbench for the quaternion arithmetic unit.
module tb;
    import qau_pkg::*;

    // Codes the block takes and drops without a result
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int unsigned N_DIRECTED_RAND = 290;

    typedef struct {
        t_req        req;
        int unsigned gap;
        bit          drain;
    } t_pend;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    qau_stream_if #(.T(t_req)) req_if ();
    qau_stream_if #(.T(t_res)) res_if ();

    quaternion_arithmetic_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_pend       req_backlog[$];
    t_res        res_due[$];
    bit          req_taken   = 1'b0;
    bit          res_taken   = 1'b0;
    bit          tx_calm     = 1'b0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_nxt;
    int unsigned n_err       = 0;
    int unsigned n_req       = 0;
    int unsigned n_matrix    = 0;
    int unsigned n_ignored   = 0;
    int unsigned n_res       = 0;

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp to the signed 16-bit range
    function automatic logic signed [15:0] q14_sat(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Q4.28 -> Q2.14, nearest with ties toward +inf, saturated
    function automatic logic signed [15:0] q14_round(longint s);
        return q14_sat((s + 8192) >>> 14);
    endfunction

    function automatic void predict_results(t_req r);
        longint ax, ay, az, aw, bx, by, bz, bw, f, one;
        t_res   o;
        ax  = r.a_x;
        ay  = r.a_y;
        az  = r.a_z;
        aw  = r.a_w;
        bx  = r.b_x;
        by  = r.b_y;
        bz  = r.b_z;
        bw  = r.b_w;
        f   = r.factor;
        one = longint'(1) << 28;
        o.last = 1'b1;
        case (r.command)
            CMD_ADD: begin
                o.res_0 = q14_sat(ax + bx);
                o.res_1 = q14_sat(ay + by);
                o.res_2 = q14_sat(az + bz);
                o.res_3 = q14_sat(aw + bw);
                res_due.push_back(o);
            end
            CMD_SUB: begin
                o.res_0 = q14_sat(ax - bx);
                o.res_1 = q14_sat(ay - by);
                o.res_2 = q14_sat(az - bz);
                o.res_3 = q14_sat(aw - bw);
                res_due.push_back(o);
            end
            CMD_MUL: begin
                o.res_0 = q14_round(aw * bx + ax * bw + ay * bz - az * by);
                o.res_1 = q14_round(aw * by + ay * bw + az * bx - ax * bz);
                o.res_2 = q14_round(aw * bz + az * bw + ax * by - ay * bx);
                o.res_3 = q14_round(aw * bw - ax * bx - ay * by - az * bz);
                res_due.push_back(o);
            end
            CMD_SCALE: begin
                o.res_0 = q14_round(ax * f);
                o.res_1 = q14_round(ay * f);
                o.res_2 = q14_round(az * f);
                o.res_3 = q14_round(aw * f);
                res_due.push_back(o);
            end
            CMD_CONJ: begin
                o.res_0 = q14_sat(-ax);
                o.res_1 = q14_sat(-ay);
                o.res_2 = q14_sat(-az);
                o.res_3 = r.a_w;
                res_due.push_back(o);
            end
            CMD_MATRIX: begin
                // One result per column, w row zero except the last column
                o.last  = 1'b0;
                o.res_3 = '0;
                o.res_0 = q14_round(one - 2 * (ay * ay + az * az));
                o.res_1 = q14_round(2 * (ax * ay - az * aw));
                o.res_2 = q14_round(2 * (ax * az + ay * aw));
                res_due.push_back(o);
                o.res_0 = q14_round(2 * (ax * ay + az * aw));
                o.res_1 = q14_round(one - 2 * (ax * ax + az * az));
                o.res_2 = q14_round(2 * (ay * az - ax * aw));
                res_due.push_back(o);
                o.res_0 = q14_round(2 * (ax * az - ay * aw));
                o.res_1 = q14_round(2 * (ay * az + ax * aw));
                o.res_2 = q14_round(one - 2 * (ax * ax + ay * ay));
                res_due.push_back(o);
                o.res_0 = '0;
                o.res_1 = '0;
                o.res_2 = '0;
                o.res_3 = Q_ONE;
                o.last  = 1'b1;
                res_due.push_back(o);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            n_err++;
        end
    endfunction

    // Predict on each accepted request, then check each accepted result
    always @(posedge clk) begin
        t_res want;
        req_taken <= rst_n && req_if.valid && req_if.ready;
        res_taken <= rst_n && res_if.valid && res_if.ready;
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                predict_results(req_if.data);
                n_req++;
                if (req_if.data.command == CMD_MATRIX) n_matrix++;
                if (req_if.data.command == CMD_RSVD6 || req_if.data.command == CMD_RSVD7)
                    n_ignored++;
            end
            if (res_if.valid && res_if.ready) begin
                n_res++;
                if (res_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %p", $time,
                             res_if.data);
                    n_err++;
                end else begin
                    want = res_due.pop_front();
                    check_field("res_0", want.res_0, res_if.data.res_0);
                    check_field("res_1", want.res_1, res_if.data.res_1);
                    check_field("res_2", want.res_2, res_if.data.res_2);
                    check_field("res_3", want.res_3, res_if.data.res_3);
                    check_field("last", want.last, res_if.data.last);
                end
            end
        end
    end

    // Request driver: hold until taken, then idle for the drawn gap
    always @(negedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            gap_left     <= 0;
        end else if (req_if.valid && !req_taken) begin
            // hold
        end else if (gap_left != 0) begin
            req_if.valid <= 1'b0;
            gap_left     <= gap_left - 1;
        end else if (req_backlog.size() != 0 &&
                     !(req_backlog[0].drain && res_due.size() != 0)) begin
            req_if.valid <= 1'b1;
            req_if.data  <= req_backlog[0].req;
            gap_left     <= req_backlog[0].gap;
            void'(req_backlog.pop_front());
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Result sink: stall a drawn number of cycles after each result,
    // with stretches of full-rate draining
    always @(negedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (res_taken)
                stall_nxt = ((n_res / 40) % 3 == 0) ? 0 : $urandom_range(7, 0);
            else
                stall_nxt = stall_left;
            if (stall_nxt == 0) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b0;
                stall_left   <= stall_nxt - 1;
            end
        end
    end

    function automatic t_req mk_req(logic [2:0] c, shortint ax, shortint ay, shortint az,
                                    shortint aw, shortint bx, shortint by, shortint bz,
                                    shortint bw, shortint f);
        t_req r;
        r.command = c;
        r.a_x     = ax;
        r.a_y     = ay;
        r.a_z     = az;
        r.a_w     = aw;
        r.b_x     = bx;
        r.b_y     = by;
        r.b_z     = bz;
        r.b_w     = bw;
        r.factor  = f;
        return r;
    endfunction

    function automatic void queue_req(t_req r, bit drain);
        t_pend p;
        p.req   = r;
        p.gap   = tx_calm ? 0 : $urandom_range(7, 0);
        p.drain = drain;
        req_backlog.push_back(p);
    endfunction

    // Mostly full range, some near zero, some at the edges and at +-1.0
    function automatic logic signed [15:0] rand_q14();
        int unsigned sel;
        sel = $urandom_range(9, 0);
        if (sel < 6) return 16'($urandom_range(65535, 0));
        if (sel < 8) return 16'($urandom_range(1023, 0) - 512);
        case ($urandom_range(4, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'sh4000;
            default: return 16'shc000;
        endcase
    endfunction

    initial begin
        logic [2:0]  ops[6];
        t_req        r;
        int unsigned counted;
        int unsigned pick;
        ops = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_SCALE, CMD_CONJ, CMD_MATRIX};

        // Edges of every operation
        queue_req(mk_req(CMD_ADD, 32767, 32767, 32767, 32767, 32767, 32767, 1, -1, 0), 0);
        queue_req(mk_req(CMD_ADD, -32768, -32768, -32768, -32768,
                         -32768, -1, 0, 32767, 0), 0);
        queue_req(mk_req(CMD_ADD, 0, 0, 0, 0, 12345, -12345, 21, -32768, 7), 0);
        queue_req(mk_req(CMD_SUB, -32768, -32768, 100, 0, 32767, 1, -100, -32768, 0), 0);
        queue_req(mk_req(CMD_SUB, 32767, 32767, -5, 0, -32768, -1, 5, 0, 0), 0);
        queue_req(mk_req(CMD_MUL, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768, 0), 0);
        queue_req(mk_req(CMD_MUL, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767, 0), 0);
        queue_req(mk_req(CMD_MUL, -32768, -32768, -32768, -32768,
                         32767, 32767, 32767, 32767, 0), 0);
        queue_req(mk_req(CMD_MUL, 1000, -2000, 3000, 16384, 0, 0, 0, 16384, 0), 0);
        queue_req(mk_req(CMD_MUL, 16384, 0, 0, 0, 0, 16384, 0, 0, 0), 0);
        queue_req(mk_req(CMD_SCALE, -32768, -32768, 32767, 32767,
                         0, 0, 0, 0, -32768), 0);
        queue_req(mk_req(CMD_SCALE, 32767, -32768, 1, -1, 0, 0, 0, 0, 32767), 0);
        // Half-way products round up, toward plus infinity
        queue_req(mk_req(CMD_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, 8192), 0);
        queue_req(mk_req(CMD_CONJ, -32768, 32767, 0, -32768, 5, 6, 7, 8, 9), 0);
        queue_req(mk_req(CMD_CONJ, 1, -1, 16384, 32767, 0, 0, 0, 0, 0), 0);
        queue_req(mk_req(CMD_MATRIX, 0, 0, 0, 16384, 0, 0, 0, 0, 0), 0);
        queue_req(mk_req(CMD_MATRIX, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0), 0);
        queue_req(mk_req(CMD_MATRIX, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0), 0);
        queue_req(mk_req(CMD_MATRIX, 16384, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        // Reserved codes: taken, no result
        queue_req(mk_req(CMD_RSVD6, 1, 2, 3, 4, 5, 6, 7, 8, 9), 0);
        queue_req(mk_req(CMD_RSVD7, -1, -2, -3, -4, -5, -6, -7, -8, -9), 0);
        queue_req(mk_req(CMD_MATRIX, 11585, 0, 0, 11585, 0, 0, 0, 0, 0), 0);

        counted = 0;
        while (counted < N_DIRECTED_RAND) begin
            tx_calm = ((counted / 50) % 3 == 1);
            pick    = $urandom_range(99, 0);
            if (pick < 2)      r.command = CMD_RSVD6;
            else if (pick < 4) r.command = CMD_RSVD7;
            else               r.command = ops[$urandom_range(5, 0)];
            r.a_x    = rand_q14();
            r.a_y    = rand_q14();
            r.a_z    = rand_q14();
            r.a_w    = rand_q14();
            r.b_x    = rand_q14();
            r.b_y    = rand_q14();
            r.b_z    = rand_q14();
            r.b_w    = rand_q14();
            r.factor = rand_q14();
            // Let the block drain completely before the random part and mid-way
            queue_req(r, counted == 0 || counted == N_DIRECTED_RAND / 2);
            if (pick >= 4) counted++;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_if.valid || res_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests (%0d matrix, %0d reserved codes), checked %0d results",
                 n_req, n_matrix, n_ignored, n_res);
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding", res_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/qau_pkg.sv
hw/rtl/qau_stream_if.sv
hw/rtl/qau_lane.sv
hw/rtl/qau_decode.sv
hw/rtl/quaternion_arithmetic_unit.sv
tb/tb.sv
